FILE: rtl/pu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_pkg - shared types and tables for the permutation unranker
// Field widths, the link and control structs of the cell row, the state
// enum and saturated factorial tables.
// ----------------------------------------------------------------------------
package pu_pkg;

    localparam int RANK_W     = 29;  // rank field
    localparam int VALUE_W    = 32;  // value field
    localparam int POS_W      = 4;   // position field
    localparam int PROD_W     = 30;  // saturated products, one bit above any rank
    localparam int OFF_W      = 5;   // element offset, covers up to 20 elements
    localparam int FACT_ARG_W = 5;   // factorial argument, 0 .. 20

    localparam logic [PROD_W-1:0] PROD_SAT = {PROD_W{1'b1}};

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } t_state;

    // control broadcast to every cell
    typedef struct packed {
        logic                  load;  // restart the row with offsets 0, 1, 2 ...
        logic                  shift; // drop the picked entry, close the gap
        logic [FACT_ARG_W-1:0] m;     // positions still to follow
        logic [RANK_W-1:0]     rem;   // remaining 0-based rank
    } t_cell_ctrl;

    // what a cell hands to its lower neighbour
    typedef struct packed {
        logic [OFF_W-1:0] offset;
        logic             ge;     // rem >= index * m!
    } t_link;

    // m!, saturated once it passes any possible rank
    function automatic logic [PROD_W-1:0] fact_sat(input logic [FACT_ARG_W-1:0] m);
        logic [PROD_W-1:0] f;
        case (m)
            5'd0:    f = 30'd1;
            5'd1:    f = 30'd1;
            5'd2:    f = 30'd2;
            5'd3:    f = 30'd6;
            5'd4:    f = 30'd24;
            5'd5:    f = 30'd120;
            5'd6:    f = 30'd720;
            5'd7:    f = 30'd5040;
            5'd8:    f = 30'd40320;
            5'd9:    f = 30'd362880;
            5'd10:   f = 30'd3628800;
            5'd11:   f = 30'd39916800;
            5'd12:   f = 30'd479001600;
            default: f = PROD_SAT;
        endcase
        return f;
    endfunction

    // k * m!, saturated; k is a fixed cell index, so this folds to a table
    function automatic logic [PROD_W-1:0] scaled_fact(input int k,
                                                      input logic [FACT_ARG_W-1:0] m);
        logic [PROD_W-1:0]            f;
        logic [PROD_W+OFF_W-1:0]      p;
        logic [PROD_W-1:0]            r;
        f = fact_sat(m);
        p = (PROD_W+OFF_W)'(f) * (PROD_W+OFF_W)'(k);
        if (k == 0) begin
            // index zero always sits at or below the remaining rank
            r = '0;
        end else if (f == PROD_SAT || p >= (PROD_W+OFF_W)'(PROD_SAT)) begin
            r = PROD_SAT;
        end else begin
            r = p[PROD_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/pu_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pu_cell - one slot of the unused-element row
// Holds one unused element offset, compares the remaining rank against
// index * m! and closes the gap when an entry at or below it is taken.
// ----------------------------------------------------------------------------
module pu_cell #(
    parameter int INDEX = 0
) (
    input  logic                      i_clk,
    input  pu_pkg::t_cell_ctrl        i_ctrl,
    input  pu_pkg::t_link             i_next,
    output pu_pkg::t_link             o_link,
    output logic [pu_pkg::OFF_W-1:0]  o_pick_offset,
    output logic [pu_pkg::PROD_W-1:0] o_pick_prod
);

    logic [pu_pkg::OFF_W-1:0]  r_offset;
    logic [pu_pkg::OFF_W-1:0]  n_offset;
    logic [pu_pkg::PROD_W-1:0] w_prod;
    logic                      w_ge;
    logic                      w_sel;

    assign w_prod = pu_pkg::scaled_fact(INDEX, i_ctrl.m);
    assign w_ge   = {1'b0, i_ctrl.rem} >= w_prod;
    // digit equals this index: threshold edge sits here
    assign w_sel  = w_ge & ~i_next.ge;

    always_comb begin
        n_offset = r_offset;
        if (i_ctrl.load) begin
            n_offset = pu_pkg::OFF_W'(INDEX);
        end else if (i_ctrl.shift && !i_next.ge) begin
            n_offset = i_next.offset;
        end
    end

    always_ff @(posedge i_clk) begin
        r_offset <= n_offset;
    end

    assign o_link        = '{offset: r_offset, ge: w_ge};
    assign o_pick_offset = w_sel ? r_offset : '0;
    assign o_pick_prod   = w_sel ? w_prod : '0;

endmodule

FILE: rtl/permutation_unrank.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank - lexicographic permutation unranking (factoradic)
// Turns a 1-based rank into the permutation of that rank over
// start_value .. start_value + element_count - 1, one beat per position.
// ----------------------------------------------------------------------------
// A rank beat in gives element_count result beats out (count clamped to
// 1 .. MAX_ELEMENTS), one per cycle while the output is free, the final beat
// flagged by m_tlast. A rank of zero or above count! gives a single beat with
// m_tuser set, m_tlast set and zero value and position. The next rank is
// taken on the cycle the final beat is registered. The pace is set by the
// cell row: one factoradic digit per cycle while the output is free, found
// by every cell at once comparing the remaining rank against its own index
// times m!, where m is the number of positions still to follow; the cell at
// the threshold edge holds the picked element and the cells above it shift
// down one slot. Config writes (element_count at index 0, start_value at
// index 1) belong in idle time; the count is sampled when a rank is accepted.
// ----------------------------------------------------------------------------
module permutation_unrank #(
    parameter int MAX_ELEMENTS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config write port
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    // rank in
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [28:0] rank, [31:29] zero
    // permutation out
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] value, [35:32] position, [39:36] zero
    output logic        m_tlast,   // last
    output logic [0:0]  m_tuser    // [0] rank_error
);

    localparam int CNT_W = $clog2(MAX_ELEMENTS + 1);

    localparam logic [0:0] CFG_COUNT = 1'b0;
    localparam logic [0:0] CFG_START = 1'b1;

    // config
    logic [3:0]                  r_cfg_count;
    logic [pu_pkg::VALUE_W-1:0]  r_cfg_start;

    // control
    pu_pkg::t_state              r_state;
    pu_pkg::t_state              n_state;
    logic [pu_pkg::RANK_W-1:0]   r_rem;
    logic [pu_pkg::RANK_W-1:0]   n_rem;
    logic [CNT_W-1:0]            r_pos;
    logic [CNT_W-1:0]            n_pos;
    logic [CNT_W-1:0]            r_n;
    logic [CNT_W-1:0]            n_n;
    logic                        r_err;
    logic                        n_err;
    logic                        r_out_valid;
    logic                        n_out_valid;

    // output payload
    logic [pu_pkg::VALUE_W-1:0]  r_value;
    logic [pu_pkg::VALUE_W-1:0]  n_value;
    logic [pu_pkg::POS_W-1:0]    r_position;
    logic [pu_pkg::POS_W-1:0]    n_position;
    logic                        r_last;
    logic                        n_last;
    logic                        r_rank_error;
    logic                        n_rank_error;

    logic [pu_pkg::RANK_W-1:0]   w_rank;
    logic [CNT_W-1:0]            w_eff;
    logic                        w_bad;
    logic                        w_out_free;
    logic                        w_step;
    logic                        w_final;
    logic                        w_accept;
    logic [CNT_W-1:0]            w_m;

    pu_pkg::t_cell_ctrl          w_ctrl;
    pu_pkg::t_link               w_link      [MAX_ELEMENTS];
    pu_pkg::t_link               w_next      [MAX_ELEMENTS];
    logic [pu_pkg::OFF_W-1:0]    w_cell_off  [MAX_ELEMENTS];
    logic [pu_pkg::PROD_W-1:0]   w_cell_prod [MAX_ELEMENTS];
    logic [MAX_ELEMENTS-1:0]     w_sel_vec;
    logic [pu_pkg::OFF_W-1:0]    w_pick_off;
    logic [pu_pkg::PROD_W-1:0]   w_pick_prod;

    // ------------------------------------------------------------------
    // config registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_count <= 4'd9;
            r_cfg_start <= 32'd1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_COUNT: r_cfg_count <= i_cfg_wdata[3:0];
                CFG_START: r_cfg_start <= i_cfg_wdata;
                default:   r_cfg_start <= r_cfg_start;
            endcase
        end
    end

    // effective count, clamped to 1 .. MAX_ELEMENTS
    always_comb begin
        if (r_cfg_count == 4'd0) begin
            w_eff = CNT_W'(1);
        end else if (32'(r_cfg_count) > MAX_ELEMENTS) begin
            w_eff = CNT_W'(MAX_ELEMENTS);
        end else begin
            w_eff = CNT_W'(r_cfg_count);
        end
    end

    assign w_rank = s_tdata[pu_pkg::RANK_W-1:0];
    assign w_bad  = (w_rank == '0) ||
                    ({1'b0, w_rank} > pu_pkg::fact_sat(pu_pkg::FACT_ARG_W'(w_eff)));

    // ------------------------------------------------------------------
    // handshake and sequencing
    // ------------------------------------------------------------------
    assign w_out_free = !r_out_valid || m_tready;
    assign w_step     = (r_state == pu_pkg::ST_RUN) && w_out_free;
    assign w_final    = r_err || (r_pos == CNT_W'(r_n - 1'b1));
    // next rank may enter on the cycle of the final beat
    assign s_tready   = (r_state == pu_pkg::ST_IDLE) || (w_step && w_final);
    assign w_accept   = s_tvalid && s_tready;
    assign w_m        = CNT_W'(r_n - r_pos - 1'b1);

    assign w_ctrl = '{load:  w_accept,
                      shift: w_step && !r_err,
                      m:     pu_pkg::FACT_ARG_W'(w_m),
                      rem:   r_rem};

    // ------------------------------------------------------------------
    // cell row: cell j holds the j-th unused element offset
    // ------------------------------------------------------------------
    for (genvar j = 0; j < MAX_ELEMENTS; j++) begin : g_cell
        if (j == MAX_ELEMENTS - 1) begin : g_end
            assign w_next[j] = '0;
        end else begin : g_mid
            assign w_next[j] = w_link[j+1];
        end

        assign w_sel_vec[j] = w_link[j].ge & ~w_next[j].ge;

        pu_cell #(
            .INDEX(j)
        ) u_cell (
            .i_clk         (i_clk),
            .i_ctrl        (w_ctrl),
            .i_next        (w_next[j]),
            .o_link        (w_link[j]),
            .o_pick_offset (w_cell_off[j]),
            .o_pick_prod   (w_cell_prod[j])
        );
    end

    // only the edge cell drives non-zero values
    always_comb begin
        w_pick_off  = '0;
        w_pick_prod = '0;
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
            w_pick_off  = w_pick_off  | w_cell_off[k];
            w_pick_prod = w_pick_prod | w_cell_prod[k];
        end
    end

    // ------------------------------------------------------------------
    // state machine
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= pu_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_pos       <= '0;
            r_n         <= CNT_W'(1);
            r_err       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_pos       <= n_pos;
            r_n         <= n_n;
            r_err       <= n_err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem        <= n_rem;
        r_value      <= n_value;
        r_position   <= n_position;
        r_last       <= n_last;
        r_rank_error <= n_rank_error;
    end

    always_comb begin
        n_state      = r_state;
        n_out_valid  = r_out_valid;
        n_rem        = r_rem;
        n_pos        = r_pos;
        n_n          = r_n;
        n_err        = r_err;
        n_value      = r_value;
        n_position   = r_position;
        n_last       = r_last;
        n_rank_error = r_rank_error;

        if (w_step) begin
            n_out_valid = 1'b1;
            if (r_err) begin
                n_value      = '0;
                n_position   = '0;
                n_last       = 1'b1;
                n_rank_error = 1'b1;
            end else begin
                n_value      = r_cfg_start + pu_pkg::VALUE_W'(w_pick_off);
                n_position   = pu_pkg::POS_W'(r_pos);
                n_last       = w_final;
                n_rank_error = 1'b0;
                n_rem        = r_rem - w_pick_prod[pu_pkg::RANK_W-1:0];
                n_pos        = CNT_W'(r_pos + 1'b1);
            end
            if (w_final) begin
                n_state = pu_pkg::ST_IDLE;
            end
        end else if (r_out_valid && m_tready) begin
            n_out_valid = 1'b0;
        end

        if (w_accept) begin
            n_state = pu_pkg::ST_RUN;
            n_rem   = w_rank - 1'b1;
            n_pos   = '0;
            n_n     = w_eff;
            n_err   = w_bad;
        end
    end

    assign m_tvalid = r_out_valid;
    assign m_tdata  = {4'b0000, r_position, r_value};
    assign m_tlast  = r_last;
    assign m_tuser  = r_rank_error;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("rank error beat without last");

    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == pu_pkg::ST_RUN) && !r_err |-> r_pos < r_n)
        else $error("position counter ran past element count");

    a_one_pick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_step && !r_err |-> $onehot(w_sel_vec))
        else $error("cell row did not pick exactly one element");

    a_accept_runs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_tvalid && s_tready |=> r_state == pu_pkg::ST_RUN)
        else $error("accepted rank did not start a run");
`endif

endmodule

FILE: dv/permutation_unrank_tb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_tb_pkg - shared items for the unranker bench
// Register indexes of the config port and the count and factorial helpers
// used by both the stimulus and the checker.
// ----------------------------------------------------------------------------
package permutation_unrank_tb_pkg;

    localparam int COUNT_LIMIT = 12;  // matches MAX_ELEMENTS of the block

    typedef enum logic [0:0] {
        REG_ELEMENT_COUNT = 1'b0,
        REG_START_VALUE   = 1'b1
    } t_cfg_reg;

    // count as the block uses it: 0 acts as 1, anything above the limit saturates
    function automatic int unsigned clamp_count(input logic [3:0] raw);
        int unsigned n;
        n = raw;
        if (n < 1) begin
            n = 1;
        end
        if (n > COUNT_LIMIT) begin
            n = COUNT_LIMIT;
        end
        return n;
    endfunction

    function automatic longint unsigned factorial(input int unsigned n);
        longint unsigned p;
        int unsigned     k;
        p = 1;
        for (k = 2; k <= n; k++) begin
            p = p * k;
        end
        return p;
    endfunction

endpackage

FILE: dv/permutation_unrank_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_checker - scoreboard for the permutation unranker
// Tracks config writes, expands every accepted rank into its expected
// permutation beats and compares each output beat field by field.
// ----------------------------------------------------------------------------
module permutation_unrank_checker
    import permutation_unrank_tb_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [31:0] i_s_tdata,   // [28:0] rank
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [39:0] i_m_tdata,   // [31:0] value, [35:32] position
    input  logic        i_m_tlast,   // last
    input  logic [0:0]  i_m_tuser,   // [0] rank_error
    output int          o_pending,
    output int          o_fail_count
);

    localparam int PRINT_CAP = 200;

    typedef struct {
        logic [31:0] value;
        logic [3:0]  position;
        logic        last;
        logic        rank_error;
    } t_perm_beat;

    t_perm_beat  perm_beat_q[$];
    logic [3:0]  count_reg  = 4'd9;
    logic [31:0] start_reg  = 32'd1;
    int          pending    = 0;
    int          fail_count = 0;

    assign o_pending    = pending;
    assign o_fail_count = fail_count;

    task automatic report_mismatch(input string msg);
        if (fail_count < PRINT_CAP) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        fail_count++;
    endtask

    // factoradic expansion of a 1-based rank under the current settings
    function automatic void unrank_perm(input logic [28:0] rank);
        int unsigned            n;
        int unsigned            i;
        int unsigned            j;
        int unsigned            seen;
        int unsigned            pick;
        longint unsigned        rem;
        longint unsigned        weight;
        longint unsigned        digit;
        logic [COUNT_LIMIT-1:0] taken;
        bit                     found;
        t_perm_beat             b;
        n = clamp_count(count_reg);
        if (rank == 0 || longint'(rank) > factorial(n)) begin
            b = '{value: '0, position: '0, last: 1'b1, rank_error: 1'b1};
            perm_beat_q.push_back(b);
            return;
        end
        rem   = longint'(rank) - 1;
        taken = '0;
        for (i = 0; i < n; i++) begin
            weight = factorial(n - 1 - i);
            digit  = rem / weight;
            rem    = rem % weight;
            seen   = 0;
            pick   = 0;
            found  = 1'b0;
            for (j = 0; j < n; j++) begin
                if (!found && !taken[j]) begin
                    if (seen == digit) begin
                        pick  = j;
                        found = 1'b1;
                    end else begin
                        seen++;
                    end
                end
            end
            taken[pick]  = 1'b1;
            b.value      = start_reg + 32'(pick);
            b.position   = 4'(i);
            b.last       = (i == n - 1);
            b.rank_error = 1'b0;
            perm_beat_q.push_back(b);
        end
    endfunction

    always @(posedge i_clk) begin
        t_perm_beat exp_beat;
        if (!i_rst_n) begin
            count_reg = 4'd9;
            start_reg = 32'd1;
            perm_beat_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_addr))
                    REG_ELEMENT_COUNT: count_reg = i_cfg_wdata[3:0];
                    REG_START_VALUE:   start_reg = i_cfg_wdata;
                    default: ;
                endcase
            end
            // output first: a beat can never stem from a rank taken on the same edge
            if (i_m_tvalid && i_m_tready) begin
                if (perm_beat_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected beat value=%0h pos=%0d",
                                              i_m_tdata[31:0], i_m_tdata[35:32]));
                end else begin
                    exp_beat = perm_beat_q.pop_front();
                    if (i_m_tdata[31:0] !== exp_beat.value) begin
                        report_mismatch($sformatf("value %h, expected %h",
                                                  i_m_tdata[31:0], exp_beat.value));
                    end
                    if (i_m_tdata[35:32] !== exp_beat.position) begin
                        report_mismatch($sformatf("position %0d, expected %0d",
                                                  i_m_tdata[35:32], exp_beat.position));
                    end
                    if (i_m_tlast !== exp_beat.last) begin
                        report_mismatch($sformatf("last %b, expected %b",
                                                  i_m_tlast, exp_beat.last));
                    end
                    if (i_m_tuser[0] !== exp_beat.rank_error) begin
                        report_mismatch($sformatf("rank_error %b, expected %b",
                                                  i_m_tuser[0], exp_beat.rank_error));
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                unrank_perm(i_s_tdata[28:0]);
            end
        end
        pending = perm_beat_q.size();
    end

    // anything still waiting once the bench has settled is a failure
    final begin
        if (perm_beat_q.size() != 0) begin
            $display("[%0t] mismatch: %0d beats never arrived", $time, perm_beat_q.size());
        end
    end

endmodule

FILE: dv/permutation_unrank_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// permutation_unrank_tb - top of the permutation unranker bench
// Drives rank beats and config writes, applies random back-pressure and
// gaps, and reports the verdict from the checker's failure count.
// ----------------------------------------------------------------------------
module permutation_unrank_tb;
    import permutation_unrank_tb_pkg::*;

    localparam int RST_CYCLES      = 9;
    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 24;   // ~190 random ranks, ~210 in all
    localparam int RX_HOLD_CYCLES  = 240;  // long receiver stall, fills the block
    localparam int SETTLE_CYCLES   = 3;    // idle margin before a config write
    localparam int TAIL_CYCLES     = 16;   // > one full permutation
    // no beat moving for this long means the block is stuck; the worst honest
    // gap comes from the receiver stall above
    localparam int IDLE_LIMIT      = 2000;

    // ---- block ports; the bench-driven inputs are all known from time zero ----
    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_cfg_we    = 1'b0;
    logic [0:0]  i_cfg_addr  = REG_ELEMENT_COUNT;
    logic [31:0] i_cfg_wdata = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata     = '0;   // [28:0] rank, [31:29] zero
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [39:0] m_tdata;            // [31:0] value, [35:32] position, [39:36] zero
    logic        m_tlast;            // last
    logic [0:0]  m_tuser;            // [0] rank_error

    int pending;
    int fail_count;
    int idle_cycles = 0;

    // knobs shared between the stimulus and the receiver
    bit quiet       = 1'b0;  // no idling on either side while set
    bit rx_hold_go  = 1'b0;  // ask the receiver for its one long stall
    bit rx_hold_done = 1'b0;

    always #6 i_clk = ~i_clk;

    permutation_unrank dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    permutation_unrank_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_addr   (i_cfg_addr),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .i_m_tlast    (m_tlast),
        .i_m_tuser    (m_tuser),
        .o_pending    (pending),
        .o_fail_count (fail_count)
    );

    // ---- watchdog: counts cycles in which no beat moves on either side ----
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= IDLE_LIMIT) begin
                $display("status: fail");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // ---- receiver: ~8% random stalls, one long stall on request ----
    initial begin : rx_side
        int hold;
        forever begin
            @(negedge i_clk);
            if (rx_hold_go && !rx_hold_done) begin
                // sender keeps offering meanwhile, so the block backs up to s_tready
                m_tready <= 1'b0;
                for (hold = 0; hold < RX_HOLD_CYCLES; hold++) begin
                    @(negedge i_clk);
                end
                rx_hold_done = 1'b1;
            end else begin
                m_tready <= quiet || ($urandom_range(0, 99) >= 8);
            end
        end
    end

    // Offer one rank beat and return at the negedge after it was taken.
    // An occasional gap goes in front so idle cycles land on every phase
    // of the block's per-position work.
    task automatic send_rank(input logic [28:0] rank);
        int gap;
        if (!quiet && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {3'b000, rank};
        do begin
            @(posedge i_clk);
        end while (!s_tready);
        @(negedge i_clk);
    endtask

    // Sender pauses until every expected beat is back, then waits out the settle
    // margin so the block is idle before the config changes under it.
    task automatic drain_block();
        s_tvalid <= 1'b0;
        while (pending != 0) begin
            @(negedge i_clk);
        end
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Both registers back to back; count word carries junk above bit 3 at times.
    task automatic write_cfg(input logic [31:0] count_word, input logic [31:0] start_word);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= REG_ELEMENT_COUNT;
        i_cfg_wdata <= count_word;
        @(negedge i_clk);
        i_cfg_addr  <= REG_START_VALUE;
        i_cfg_wdata <= start_word;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Mostly in-range ranks (the corners 1 and count! favoured), the rest
    // zero, just past count!, or any 29-bit pattern at all.
    function automatic logic [28:0] pick_rank(input logic [3:0] count_raw);
        longint unsigned span;
        longint unsigned r;
        int              sel;
        span = factorial(clamp_count(count_raw));
        sel  = $urandom_range(0, 99);
        if (sel < 5) begin
            r = 1;
        end else if (sel < 10) begin
            r = span;
        end else if (sel < 82) begin
            r = 1 + ({$urandom(), $urandom()} % span);
        end else if (sel < 88) begin
            r = 0;
        end else if (sel < 94) begin
            r = span + 1 + $urandom_range(0, 3);
        end else begin
            r = $urandom();
        end
        return r[28:0];
    endfunction

    // ---- stimulus and verdict ----
    initial begin : stimulus
        int         ph;
        int         k;
        logic [3:0] cnt;
        repeat (RST_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset settings: nine elements from 1
        send_rank(29'd1);
        send_rank(29'd362880);        // last permutation, fully reversed
        send_rank(29'd0);             // bad rank: zero
        send_rank(29'd362881);        // bad rank: one past count!
        send_rank(29'd2);
        send_rank(29'h1FFF_FFFF);     // all rank bits set, bad
        send_rank(29'd100000);
        drain_block();

        // full width, values wrap past the top of the signed range
        write_cfg(32'd12, 32'h7FFF_FFFE);
        send_rank(29'd1);
        send_rank(29'd479001600);
        send_rank(29'd479001601);
        send_rank(29'd239500800);
        drain_block();

        // single element
        write_cfg(32'd1, 32'h8000_0000);
        send_rank(29'd1);
        send_rank(29'd2);
        send_rank(29'd0);
        drain_block();

        // a count of zero acts as one; upper write data bits are don't-care
        write_cfg(32'hFFFF_FFF0, 32'hFFFF_FFFF);
        send_rank(29'd1);
        send_rank(29'd2);
        drain_block();

        // counts above the limit saturate at twelve
        write_cfg(32'h0000_000F, 32'h0000_0000);
        send_rank(29'd479001600);
        send_rank(29'd1);
        send_rank(29'd479001601);
        drain_block();
        write_cfg(32'hA5A5_A5AD, 32'h0000_0000);
        send_rank(29'd12345678);
        drain_block();

        // random settings; the first phase at full width carries the long
        // receiver stall, the third runs with no idling at all
        for (ph = 0; ph < RAND_PHASES; ph++) begin
            cnt = (ph == 0) ? 4'd12 : 4'($urandom_range(0, 15));
            write_cfg({28'($urandom()), cnt}, $urandom());
            quiet = (ph == 2);
            if (ph == 0) begin
                rx_hold_go = 1'b1;
            end
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                send_rank(pick_rank(cnt));
            end
            drain_block();
        end
        quiet = 1'b0;

        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
